### src/gamepad_report_conditioner_macros.svh
// ---------------------------------------------------------------------------
// Gamepad report conditioner assertion macros
// Shorthand for clocked assertions in the checker; expects clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_CONDITIONER_MACROS_SVH
`define GAMEPAD_REPORT_CONDITIONER_MACROS_SVH

// same-cycle implication
`define GPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gpc_pkg.sv
// ---------------------------------------------------------------------------
// Gamepad report conditioner package
// Shared constants, codes and word types for the conditioner modules.
// ---------------------------------------------------------------------------
package gpc_pkg;

  localparam int NUM_PADS    = 4;
  localparam int PAD_W       = 2;
  localparam int NUM_STICKS  = 4;
  localparam int NUM_TRIGS   = 2;
  localparam int NUM_OPS     = NUM_STICKS + NUM_TRIGS;
  localparam int OP_IDX_W    = $clog2(NUM_OPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [14:0] STICK_FULL = 15'd32767;
  localparam logic [14:0] TRIG_FULL  = 15'd255;

  // shared divider: 30-bit dividend, 15-bit divisor and quotient
  localparam int DIV_Q_W     = 15;
  localparam int DIV_N_W     = 2 * DIV_Q_W;
  localparam int DIV_BITS    = 3;
  localparam int DIV_CYCLES  = DIV_Q_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_DZ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_DZ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LTRIG_BIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RTRIG_BIT = 3'd4;

  // queued word kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_FAIL   = 2'd1;
  localparam logic [1:0] KIND_ARM    = 2'd2;

  typedef struct packed {
    logic [14:0] stick_dz;
    logic [7:0]  trig_dz;
    logic [14:0] trig_thr;
    logic [3:0]  ltrig_bit;
    logic [3:0]  rtrig_bit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [PAD_W-1:0]            pad;
    logic [15:0]                 buttons;
    logic [NUM_STICKS-1:0][14:0] mag;
    logic [NUM_STICKS-1:0]       neg;
    logic [NUM_TRIGS-1:0][7:0]   trig;
    logic [15:0]                 elapsed;
    logic [15:0]                 vibration;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_Q_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

### src/gamepad_report_conditioner.sv
// ---------------------------------------------------------------------------
// Gamepad report conditioner
// Per-pad stick, trigger and button conditioning with vibration countdown.
// ---------------------------------------------------------------------------
// Input words arrive on in_valid/in_ready: a pad report or a vibration arm.
// Each report gives one result word on out_valid/out_ready; arm words and
// words for pads out of range give none. Registers are written on the
// cfg_valid/cfg_ready port (always ready); the user must write them only
// while the block is idle, which the block itself does not enforce. The
// front end takes a word into a two-entry queue; the back end drains it
// one word at a time. A report runs six rescales on a shared divider that
// retires three quotient bits a cycle; a rescale skips the divider when the
// value sits in the dead zone. A result waits in the output register while
// out_ready is low; the back end holds its next result until that register
// frees, and the front end keeps taking words until the queue fills.
// Synchronous reset sets all pads disconnected, clears stored buttons and
// countdowns, empties the queue and loads the register defaults.
// ---------------------------------------------------------------------------
module gamepad_report_conditioner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [gpc_pkg::PAD_W-1:0]     in_pad_index,
  input  logic                          in_poll_ok,
  input  logic [15:0]                   in_raw_buttons,
  input  logic signed [15:0]            in_raw_left_x,
  input  logic signed [15:0]            in_raw_left_y,
  input  logic signed [15:0]            in_raw_right_x,
  input  logic signed [15:0]            in_raw_right_y,
  input  logic [7:0]                    in_raw_left_trigger,
  input  logic [7:0]                    in_raw_right_trigger,
  input  logic [15:0]                   in_elapsed_ms,
  input  logic [15:0]                   in_vibration_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gpc_pkg::PAD_W-1:0]     out_pad_index,
  output logic                          out_connected,
  output logic [15:0]                   out_buttons,
  output logic [15:0]                   out_pressed_edges,
  output logic [15:0]                   out_released_edges,
  output logic signed [15:0]            out_left_x,
  output logic signed [15:0]            out_left_y,
  output logic signed [15:0]            out_right_x,
  output logic signed [15:0]            out_right_y,
  output logic [14:0]                   out_left_trigger,
  output logic [14:0]                   out_right_trigger,
  output logic                          out_vibration_stop
);

  gpc_pkg::cfg_t     cfg_r, cfg_nxt;
  gpc_pkg::item_t    push_word, head_word;
  gpc_pkg::div_req_t div_req;
  gpc_pkg::div_rsp_t div_rsp;
  logic              q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gpc_pkg::REG_STICK_DZ:  cfg_nxt.stick_dz  = cfg_data[14:0];
        gpc_pkg::REG_TRIG_DZ:   cfg_nxt.trig_dz   = cfg_data[7:0];
        gpc_pkg::REG_TRIG_THR:  cfg_nxt.trig_thr  = cfg_data[14:0];
        gpc_pkg::REG_LTRIG_BIT: cfg_nxt.ltrig_bit = cfg_data[3:0];
        gpc_pkg::REG_RTRIG_BIT: cfg_nxt.rtrig_bit = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_dz  <= 15'd7849;
      cfg_r.trig_dz   <= 8'd30;
      cfg_r.trig_thr  <= 15'd16384;
      cfg_r.ltrig_bit <= 4'd10;
      cfg_r.rtrig_bit <= 4'd11;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gpc_front u_front (
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_pad_index         (in_pad_index),
    .in_poll_ok           (in_poll_ok),
    .in_raw_buttons       (in_raw_buttons),
    .in_raw_left_x        (in_raw_left_x),
    .in_raw_left_y        (in_raw_left_y),
    .in_raw_right_x       (in_raw_right_x),
    .in_raw_right_y       (in_raw_right_y),
    .in_raw_left_trigger  (in_raw_left_trigger),
    .in_raw_right_trigger (in_raw_right_trigger),
    .in_elapsed_ms        (in_elapsed_ms),
    .in_vibration_ms      (in_vibration_ms),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_word               (push_word)
  );

  gpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .head      (head_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  gpc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gpc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_head             (head_word),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pad_index      (out_pad_index),
    .out_connected      (out_connected),
    .out_buttons        (out_buttons),
    .out_pressed_edges  (out_pressed_edges),
    .out_released_edges (out_released_edges),
    .out_left_x         (out_left_x),
    .out_left_y         (out_left_y),
    .out_right_x        (out_right_x),
    .out_right_y        (out_right_y),
    .out_left_trigger   (out_left_trigger),
    .out_right_trigger  (out_right_trigger),
    .out_vibration_stop (out_vibration_stop)
  );

endmodule

### src/gpc_front.sv
// ---------------------------------------------------------------------------
// Gamepad report conditioner front end
// Accepts input words, drops bad pads, classifies and folds stick signs.
// ---------------------------------------------------------------------------
module gpc_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [gpc_pkg::PAD_W-1:0] in_pad_index,
  input  logic                      in_poll_ok,
  input  logic [15:0]               in_raw_buttons,
  input  logic signed [15:0]        in_raw_left_x,
  input  logic signed [15:0]        in_raw_left_y,
  input  logic signed [15:0]        in_raw_right_x,
  input  logic signed [15:0]        in_raw_right_y,
  input  logic [7:0]                in_raw_left_trigger,
  input  logic [7:0]                in_raw_right_trigger,
  input  logic [15:0]               in_elapsed_ms,
  input  logic [15:0]               in_vibration_ms,
  input  logic                      q_full,
  output logic                      q_push,
  output gpc_pkg::item_t            q_word
);

  logic [gpc_pkg::NUM_STICKS-1:0][15:0] raw;
  logic [gpc_pkg::NUM_STICKS-1:0][15:0] absv;
  logic                                 pad_ok;

  assign raw[0] = in_raw_left_x;
  assign raw[1] = in_raw_left_y;
  assign raw[2] = in_raw_right_x;
  assign raw[3] = in_raw_right_y;

  assign in_ready = !q_full;
  assign pad_ok   = int'(in_pad_index) < gpc_pkg::NUM_PADS;
  assign q_push   = in_valid && in_ready && pad_ok;

  always_comb begin
    q_word           = '0;
    q_word.kind      = in_action ? gpc_pkg::KIND_ARM :
                       (in_poll_ok ? gpc_pkg::KIND_REPORT : gpc_pkg::KIND_FAIL);
    q_word.pad       = in_pad_index;
    q_word.buttons   = in_raw_buttons;
    q_word.trig[0]   = in_raw_left_trigger;
    q_word.trig[1]   = in_raw_right_trigger;
    q_word.elapsed   = in_elapsed_ms;
    q_word.vibration = in_vibration_ms;
    for (int i = 0; i < gpc_pkg::NUM_STICKS; i++) begin
      absv[i]       = raw[i][15] ? (16'd0 - raw[i]) : raw[i];
      q_word.neg[i] = raw[i][15];
      // -32768 clamps to -32767
      q_word.mag[i] = absv[i][15] ? gpc_pkg::STICK_FULL : absv[i][14:0];
    end
  end

endmodule

### src/gpc_queue.sv
// ---------------------------------------------------------------------------
// Gamepad report conditioner queue
// Short register FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
module gpc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gpc_pkg::item_t push_word,
  input  logic           pop,
  output gpc_pkg::item_t head,
  output logic           full,
  output logic           empty
);

  gpc_pkg::item_t                    mem_r [gpc_pkg::QUEUE_DEPTH];
  logic [gpc_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [gpc_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [gpc_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  assign full    = cnt_r == gpc_pkg::Q_CNT_W'(gpc_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == gpc_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == gpc_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

### src/gpc_divider.sv
// ---------------------------------------------------------------------------
// Gamepad report conditioner divider
// Shared restoring divider, three quotient bits per cycle.
// ---------------------------------------------------------------------------
module gpc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  gpc_pkg::div_req_t req,
  output gpc_pkg::div_rsp_t rsp
);

  logic [gpc_pkg::DIV_Q_W-1:0]   rem_r, rem_nxt;
  logic [gpc_pkg::DIV_Q_W-1:0]   quo_r, quo_nxt;
  logic [gpc_pkg::DIV_Q_W-1:0]   den_r, den_nxt;
  logic [gpc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [gpc_pkg::DIV_Q_W:0]     trial;

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (busy_r) begin
      for (int i = 0; i < gpc_pkg::DIV_BITS; i++) begin
        trial = {rem_nxt, quo_nxt[gpc_pkg::DIV_Q_W-1]};
        if (trial >= {1'b0, den_r}) begin
          trial   = trial - {1'b0, den_r};
          quo_nxt = {quo_nxt[gpc_pkg::DIV_Q_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[gpc_pkg::DIV_Q_W-2:0], 1'b0};
        end
        rem_nxt = trial[gpc_pkg::DIV_Q_W-1:0];
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (req.start) begin
      // high half is below the divisor, so the quotient fits 15 bits
      rem_nxt  = req.dividend[gpc_pkg::DIV_N_W-1:gpc_pkg::DIV_Q_W];
      quo_nxt  = req.dividend[gpc_pkg::DIV_Q_W-1:0];
      den_nxt  = req.divisor;
      cnt_nxt  = gpc_pkg::DIV_CNT_W'(gpc_pkg::DIV_CYCLES - 1);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

endmodule

### src/gpc_back.sv
// ---------------------------------------------------------------------------
// Gamepad report conditioner back end
// Sequences the six rescales, keeps per-pad state, drives the result word.
// ---------------------------------------------------------------------------
module gpc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gpc_pkg::cfg_t             cfg,
  input  gpc_pkg::item_t            q_head,
  input  logic                      q_empty,
  output logic                      q_pop,
  output gpc_pkg::div_req_t         div_req,
  input  gpc_pkg::div_rsp_t         div_rsp,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gpc_pkg::PAD_W-1:0] out_pad_index,
  output logic                      out_connected,
  output logic [15:0]               out_buttons,
  output logic [15:0]               out_pressed_edges,
  output logic [15:0]               out_released_edges,
  output logic signed [15:0]        out_left_x,
  output logic signed [15:0]        out_left_y,
  output logic signed [15:0]        out_right_x,
  output logic signed [15:0]        out_right_y,
  output logic [14:0]               out_left_trigger,
  output logic [14:0]               out_right_trigger,
  output logic                      out_vibration_stop
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOAD   = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [gpc_pkg::OP_IDX_W-1:0]  k_r, k_nxt;
  gpc_pkg::item_t                item_r, item_nxt;
  logic [14:0]                   res_r [gpc_pkg::NUM_OPS];
  logic [14:0]                   res_nxt [gpc_pkg::NUM_OPS];
  logic [15:0]                   prev_r [gpc_pkg::NUM_PADS];
  logic [15:0]                   prev_nxt [gpc_pkg::NUM_PADS];
  logic [15:0]                   vib_r [gpc_pkg::NUM_PADS];
  logic [15:0]                   vib_nxt [gpc_pkg::NUM_PADS];
  logic [gpc_pkg::NUM_PADS-1:0]  conn_r, conn_nxt;

  logic                          ov_r, ov_nxt;
  logic [gpc_pkg::PAD_W-1:0]     o_pad_r, o_pad_nxt;
  logic                          o_conn_r, o_conn_nxt;
  logic [15:0]                   o_btn_r, o_btn_nxt;
  logic [15:0]                   o_pe_r, o_pe_nxt;
  logic [15:0]                   o_re_r, o_re_nxt;
  logic [gpc_pkg::NUM_STICKS-1:0][15:0] o_stick_r, o_stick_nxt;
  logic [14:0]                   o_lt_r, o_lt_nxt;
  logic [14:0]                   o_rt_r, o_rt_nxt;
  logic                          o_stop_r, o_stop_nxt;

  logic [14:0]                   op_mag, op_dz, op_full, op_den, op_diff;
  logic                          op_skip, last_op, out_free;
  logic [gpc_pkg::DIV_N_W-1:0]   op_scaled;
  logic [15:0]                   now_btn, prev_btn, cur_vib;

  assign out_valid          = ov_r;
  assign out_pad_index      = o_pad_r;
  assign out_connected      = o_conn_r;
  assign out_buttons        = o_btn_r;
  assign out_pressed_edges  = o_pe_r;
  assign out_released_edges = o_re_r;
  assign out_left_x         = o_stick_r[0];
  assign out_left_y         = o_stick_r[1];
  assign out_right_x        = o_stick_r[2];
  assign out_right_y        = o_stick_r[3];
  assign out_left_trigger   = o_lt_r;
  assign out_right_trigger  = o_rt_r;
  assign out_vibration_stop = o_stop_r;

  assign out_free = !ov_r || out_ready;
  assign last_op  = int'(k_r) == gpc_pkg::NUM_OPS - 1;

  // operand for rescale k: sticks first, then triggers
  always_comb begin
    if (int'(k_r) < gpc_pkg::NUM_STICKS) begin
      op_mag  = item_r.mag[k_r[1:0]];
      op_dz   = cfg.stick_dz;
      op_full = gpc_pkg::STICK_FULL;
    end else begin
      op_mag  = {7'd0, item_r.trig[k_r[0]]};
      op_dz   = {7'd0, cfg.trig_dz};
      op_full = gpc_pkg::TRIG_FULL;
    end
    op_skip   = (op_mag <= op_dz) || (op_dz >= op_full);
    op_den    = op_full - op_dz;
    op_diff   = op_mag - op_dz;
    op_scaled = {op_diff, 15'd0} - {15'd0, op_diff};
  end

  always_comb begin
    div_req.start    = (state_r == S_LOAD) && !op_skip && !div_rsp.busy;
    div_req.dividend = op_scaled + gpc_pkg::DIV_N_W'(op_den[14:1]);
    div_req.divisor  = op_den;
  end

  always_comb begin
    prev_btn = prev_r[item_r.pad];
    cur_vib  = vib_r[item_r.pad];
    now_btn  = item_r.buttons;
    if (res_r[gpc_pkg::NUM_STICKS] > cfg.trig_thr) begin
      now_btn = now_btn | (16'd1 << cfg.ltrig_bit);
    end
    if (res_r[gpc_pkg::NUM_STICKS + 1] > cfg.trig_thr) begin
      now_btn = now_btn | (16'd1 << cfg.rtrig_bit);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    item_nxt    = item_r;
    res_nxt     = res_r;
    prev_nxt    = prev_r;
    vib_nxt     = vib_r;
    conn_nxt    = conn_r;
    q_pop       = 1'b0;
    ov_nxt      = ov_r && !out_ready;
    o_pad_nxt   = o_pad_r;
    o_conn_nxt  = o_conn_r;
    o_btn_nxt   = o_btn_r;
    o_pe_nxt    = o_pe_r;
    o_re_nxt    = o_re_r;
    o_stick_nxt = o_stick_r;
    o_lt_nxt    = o_lt_r;
    o_rt_nxt    = o_rt_r;
    o_stop_nxt  = o_stop_r;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_head;
          k_nxt    = '0;
          case (q_head.kind)
            gpc_pkg::KIND_ARM: begin
              if (conn_r[q_head.pad]) begin
                vib_nxt[q_head.pad] = q_head.vibration;
              end
            end
            gpc_pkg::KIND_FAIL: state_nxt = S_FINISH;
            default:            state_nxt = S_LOAD;
          endcase
        end
      end
      S_LOAD: begin
        if (op_skip) begin
          res_nxt[k_r] = '0;
          state_nxt    = last_op ? S_FINISH : S_LOAD;
          k_nxt        = last_op ? k_r : k_r + 1'b1;
        end else if (div_req.start) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          res_nxt[k_r] = div_rsp.quotient;
          state_nxt    = last_op ? S_FINISH : S_LOAD;
          k_nxt        = last_op ? k_r : k_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_pad_nxt   = item_r.pad;
          o_conn_nxt  = 1'b0;
          o_btn_nxt   = '0;
          o_pe_nxt    = '0;
          o_re_nxt    = '0;
          o_stick_nxt = '0;
          o_lt_nxt    = '0;
          o_rt_nxt    = '0;
          o_stop_nxt  = 1'b0;
          state_nxt   = S_IDLE;
          if (item_r.kind == gpc_pkg::KIND_FAIL) begin
            conn_nxt[item_r.pad] = 1'b0;
            prev_nxt[item_r.pad] = '0;
            vib_nxt[item_r.pad]  = '0;
          end else begin
            conn_nxt[item_r.pad] = 1'b1;
            prev_nxt[item_r.pad] = now_btn;
            o_conn_nxt = 1'b1;
            o_btn_nxt  = now_btn;
            o_pe_nxt   = now_btn & ~prev_btn;
            o_re_nxt   = ~now_btn & prev_btn;
            o_lt_nxt   = res_r[gpc_pkg::NUM_STICKS];
            o_rt_nxt   = res_r[gpc_pkg::NUM_STICKS + 1];
            for (int i = 0; i < gpc_pkg::NUM_STICKS; i++) begin
              o_stick_nxt[i] = item_r.neg[i] ? (16'd0 - {1'b0, res_r[i]}) : {1'b0, res_r[i]};
            end
            if (cur_vib != '0) begin
              if (item_r.elapsed >= cur_vib) begin
                vib_nxt[item_r.pad] = '0;
                o_stop_nxt = 1'b1;
              end else begin
                vib_nxt[item_r.pad] = cur_vib - item_r.elapsed;
              end
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      conn_r  <= '0;
      ov_r    <= 1'b0;
      for (int p = 0; p < gpc_pkg::NUM_PADS; p++) begin
        prev_r[p] <= '0;
        vib_r[p]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      conn_r  <= conn_nxt;
      ov_r    <= ov_nxt;
      prev_r  <= prev_nxt;
      vib_r   <= vib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    res_r     <= res_nxt;
    o_pad_r   <= o_pad_nxt;
    o_conn_r  <= o_conn_nxt;
    o_btn_r   <= o_btn_nxt;
    o_pe_r    <= o_pe_nxt;
    o_re_r    <= o_re_nxt;
    o_stick_r <= o_stick_nxt;
    o_lt_r    <= o_lt_nxt;
    o_rt_r    <= o_rt_nxt;
    o_stop_r  <= o_stop_nxt;
  end

endmodule

### src/gpc_checker.sv
// ---------------------------------------------------------------------------
// Gamepad report conditioner checker
// Port-level assertions on result words, bound to the top level.
// ---------------------------------------------------------------------------
`include "gamepad_report_conditioner_macros.svh"

module gpc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gpc_pkg::PAD_W-1:0]      out_pad_index,
  input logic                           out_connected,
  input logic [15:0]                    out_buttons,
  input logic [15:0]                    out_pressed_edges,
  input logic [15:0]                    out_released_edges,
  input logic [15:0]                    out_left_x,
  input logic [15:0]                    out_left_y,
  input logic [15:0]                    out_right_x,
  input logic [15:0]                    out_right_y,
  input logic [14:0]                    out_left_trigger,
  input logic [14:0]                    out_right_trigger,
  input logic                           out_vibration_stop
);

  `GPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid,
    "result word dropped while stalled")

  `GPC_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
    $stable(out_pad_index) && $stable(out_connected) && $stable(out_buttons) &&
    $stable(out_pressed_edges) && $stable(out_released_edges) &&
    $stable(out_left_x) && $stable(out_left_y) && $stable(out_right_x) &&
    $stable(out_right_y) && $stable(out_left_trigger) && $stable(out_right_trigger) &&
    $stable(out_vibration_stop),
    "result word changed while stalled")

  `GPC_ASSERT_IMP(a_disc_zero, out_valid && !out_connected,
    out_buttons == 16'd0 && out_pressed_edges == 16'd0 && out_released_edges == 16'd0 &&
    out_left_x == 16'd0 && out_left_y == 16'd0 && out_right_x == 16'd0 &&
    out_right_y == 16'd0 && out_left_trigger == 15'd0 && out_right_trigger == 15'd0 &&
    !out_vibration_stop,
    "disconnected pad reports nonzero fields")

  `GPC_ASSERT_IMP(a_edges, out_valid,
    (out_pressed_edges & ~out_buttons) == 16'd0 && (out_released_edges & out_buttons) == 16'd0,
    "edge masks disagree with buttons")

  `GPC_ASSERT_IMP(a_stick_range, out_valid,
    out_left_x != 16'h8000 && out_left_y != 16'h8000 &&
    out_right_x != 16'h8000 && out_right_y != 16'h8000,
    "stick output outside symmetric range")

endmodule

bind gamepad_report_conditioner gpc_checker u_gpc_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gamepad report conditioner testbench
// Sends pad reports and vibration arm words through the valid/ready ports
// with random idling on both sides. A behavioural copy of the conditioner
// predicts each result word, and every result is checked field by field.
// ---------------------------------------------------------------------------
module tb;

  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_ARM    = 1'b1;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 135;
  localparam int unsigned FULL_Q    = int'(gpc_pkg::STICK_FULL);
  localparam int unsigned TRIG_SPAN = int'(gpc_pkg::TRIG_FULL);

  typedef struct packed {
    logic                      action;
    logic [gpc_pkg::PAD_W-1:0] pad;
    logic                      poll_ok;
    logic [15:0]               buttons;
    logic [15:0]               lx, ly, rx, ry;
    logic [7:0]                lt, rt;
    logic [15:0]               elapsed;
    logic [15:0]               vib_ms;
  } pad_word_t;

  typedef struct packed {
    logic [gpc_pkg::PAD_W-1:0] pad;
    logic                      connected;
    logic [15:0]               buttons, pressed, released;
    logic [15:0]               lx, ly, rx, ry;
    logic [14:0]               lt, rt;
    logic                      vib_stop;
  } pad_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gpc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, in_action, in_poll_ok;
  logic [gpc_pkg::PAD_W-1:0] in_pad_index;
  logic [15:0] in_raw_buttons, in_elapsed_ms, in_vibration_ms;
  logic signed [15:0] in_raw_left_x, in_raw_left_y, in_raw_right_x, in_raw_right_y;
  logic [7:0] in_raw_left_trigger, in_raw_right_trigger;
  logic out_valid, out_ready, out_connected, out_vibration_stop;
  logic [gpc_pkg::PAD_W-1:0] out_pad_index;
  logic [15:0] out_buttons, out_pressed_edges, out_released_edges;
  logic signed [15:0] out_left_x, out_left_y, out_right_x, out_right_y;
  logic [14:0] out_left_trigger, out_right_trigger;

  // conditioner state as predicted
  int unsigned dz_stick, dz_trig, press_thr, ltrig_bit, rtrig_bit;
  logic [15:0] held_buttons [gpc_pkg::NUM_PADS];
  logic        pad_live [gpc_pkg::NUM_PADS];
  logic [15:0] rumble_ms [gpc_pkg::NUM_PADS];
  pad_result_t pending_reports [$];
  pad_result_t want_r;

  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  gamepad_report_conditioner dut (.*);

  always #1 clk = ~clk;

  function automatic int unsigned rescale_mag(int unsigned mag, int unsigned dz,
                                              int unsigned full);
    int unsigned span, q;
    if (mag <= dz || dz >= full) return 0;
    span = full - dz;
    q = ((mag - dz) * FULL_Q + span / 2) / span;
    return (q > FULL_Q) ? FULL_Q : q;
  endfunction

  function automatic logic [15:0] condition_axis(logic [15:0] raw);
    int v;
    int unsigned q;
    v = int'($signed(raw));
    if (v < -32767) v = -32767;
    q = rescale_mag(v < 0 ? -v : v, dz_stick, FULL_Q);
    return (v < 0) ? 16'(0 - q) : 16'(q);
  endfunction

  function automatic void condition_report(pad_word_t w);
    pad_result_t r;
    int unsigned lt, rt;
    logic [15:0] now;
    if (w.action == ACT_ARM) begin
      if (pad_live[w.pad]) rumble_ms[w.pad] = w.vib_ms;
      return;
    end
    r = '0;
    r.pad = w.pad;
    if (!w.poll_ok) begin
      pad_live[w.pad] = 1'b0;
      held_buttons[w.pad] = '0;
      rumble_ms[w.pad] = '0;
    end else begin
      pad_live[w.pad] = 1'b1;
      lt = rescale_mag(w.lt, dz_trig, TRIG_SPAN);
      rt = rescale_mag(w.rt, dz_trig, TRIG_SPAN);
      now = w.buttons;
      if (lt > press_thr) now[ltrig_bit] = 1'b1;
      if (rt > press_thr) now[rtrig_bit] = 1'b1;
      r.connected = 1'b1;
      r.buttons = now;
      r.pressed = now & ~held_buttons[w.pad];
      r.released = ~now & held_buttons[w.pad];
      held_buttons[w.pad] = now;
      r.lx = condition_axis(w.lx);
      r.ly = condition_axis(w.ly);
      r.rx = condition_axis(w.rx);
      r.ry = condition_axis(w.ry);
      r.lt = 15'(lt);
      r.rt = 15'(rt);
      if (rumble_ms[w.pad] != 0) begin
        if (w.elapsed >= rumble_ms[w.pad]) begin
          rumble_ms[w.pad] = '0;
          r.vib_stop = 1'b1;
        end else begin
          rumble_ms[w.pad] = rumble_ms[w.pad] - w.elapsed;
        end
      end
    end
    pending_reports = {pending_reports, r};
  endfunction

  function automatic logic [15:0] reg_mask(logic [gpc_pkg::CFG_IDX_W-1:0] idx);
    case (idx)
      gpc_pkg::REG_STICK_DZ, gpc_pkg::REG_TRIG_THR:   return 16'h7FFF;
      gpc_pkg::REG_TRIG_DZ:                           return 16'h00FF;
      gpc_pkg::REG_LTRIG_BIT, gpc_pkg::REG_RTRIG_BIT: return 16'h000F;
      default:                                        return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] random_axis();
    int v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = -32767;
          2: v = 32767;
          default: v = 0;
        endcase
      end
      1, 2: begin
        v = int'(dz_stick) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = int'($signed(16'($urandom())));
    endcase
    return 16'(v);
  endfunction

  function automatic logic [7:0] random_trigger();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1) ? 255 : 0;
      1: begin
        v = int'(dz_trig) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = int'($urandom_range(0, 255));
    endcase
    return 8'(v);
  endfunction

  // mostly live reports with evolving buttons, some arms and failed polls
  function automatic pad_word_t random_word();
    pad_word_t w;
    w.action = ($urandom_range(0, 99) < 12) ? ACT_ARM : ACT_REPORT;
    w.pad = gpc_pkg::PAD_W'($urandom_range(0, gpc_pkg::NUM_PADS - 1));
    w.poll_ok = ($urandom_range(0, 99) >= 8);
    if ($urandom_range(0, 2) == 0) w.buttons = 16'($urandom());
    else w.buttons = held_buttons[w.pad] ^ (16'h1 << $urandom_range(0, 15));
    w.lx = random_axis();
    w.ly = random_axis();
    w.rx = random_axis();
    w.ry = random_axis();
    w.lt = random_trigger();
    w.rt = random_trigger();
    w.elapsed = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 150));
    case ($urandom_range(0, 7))
      0: w.vib_ms = '0;
      1: w.vib_ms = 16'($urandom());
      default: w.vib_ms = 16'($urandom_range(1, 600));
    endcase
    return w;
  endfunction

  function automatic pad_word_t make_report(int pad, bit ok, logic [15:0] buttons,
                                            int lx, ly, rx, ry, lt, rt, elapsed);
    pad_word_t w;
    w = random_word();
    w.action = ACT_REPORT;
    w.pad = gpc_pkg::PAD_W'(pad);
    w.poll_ok = ok;
    w.buttons = buttons;
    w.lx = 16'(lx);
    w.ly = 16'(ly);
    w.rx = 16'(rx);
    w.ry = 16'(ry);
    w.lt = 8'(lt);
    w.rt = 8'(rt);
    w.elapsed = 16'(elapsed);
    return w;
  endfunction

  function automatic pad_word_t make_arm(int pad, int ms);
    pad_word_t w;
    w = random_word();
    w.action = ACT_ARM;
    w.pad = gpc_pkg::PAD_W'(pad);
    w.vib_ms = 16'(ms);
    return w;
  endfunction

  task automatic write_reg(input logic [gpc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] value,
                           input bit last);
    logic [15:0] data;
    data = (16'($urandom()) & ~reg_mask(idx)) | (value & reg_mask(idx));
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gpc_pkg::REG_STICK_DZ:  dz_stick = data[14:0];
      gpc_pkg::REG_TRIG_DZ:   dz_trig = data[7:0];
      gpc_pkg::REG_TRIG_THR:  press_thr = data[14:0];
      gpc_pkg::REG_LTRIG_BIT: ltrig_bit = data[3:0];
      gpc_pkg::REG_RTRIG_BIT: rtrig_bit = data[3:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input int unsigned sdz, tdz, thr, lb, rb);
    write_reg(gpc_pkg::REG_STICK_DZ, 16'(sdz), 1'b0);
    write_reg(gpc_pkg::REG_TRIG_DZ, 16'(tdz), 1'b0);
    write_reg(gpc_pkg::REG_TRIG_THR, 16'(thr), 1'b0);
    write_reg(gpc_pkg::REG_LTRIG_BIT, 16'(lb), 1'b0);
    write_reg(gpc_pkg::REG_RTRIG_BIT, 16'(rb), 1'b1);
  endtask

  task automatic send_word(input pad_word_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= w.action;
    in_pad_index <= w.pad;
    in_poll_ok <= w.poll_ok;
    in_raw_buttons <= w.buttons;
    in_raw_left_x <= w.lx;
    in_raw_left_y <= w.ly;
    in_raw_right_x <= w.rx;
    in_raw_right_y <= w.ry;
    in_raw_left_trigger <= w.lt;
    in_raw_right_trigger <= w.rt;
    in_elapsed_ms <= w.elapsed;
    in_vibration_ms <= w.vib_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    condition_report(w);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // arm words give no result, so allow them to clear the queue too
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_word(make_report(0, 0, 16'hFFFF, 'h1234, -32768, 32767, -1, 255, 128, 16));
    send_word(make_arm(1, 500));
    send_word(make_report(1, 1, 16'h0000, 0, 0, 0, 0, 0, 0, 65535));
    send_word(make_report(0, 1, 16'hFFFF, -32768, 32767, -32767, 0, 255, 0, 0));
    send_word(make_report(0, 1, 16'h0000, 7849, -7849, 7850, -7850, 30, 31, 0));
    send_word(make_report(0, 1, 16'h5A5A, 1, -1, 32766, -32766, 254, 1, 0));
    send_word(make_arm(0, 100));
    send_word(make_report(0, 1, 16'h5A5A, 0, 0, 0, 0, 0, 0, 40));
    send_word(make_report(0, 1, 16'h5A5B, 0, 0, 0, 0, 0, 0, 60));
    send_word(make_report(0, 1, 16'h5A5B, 0, 0, 0, 0, 0, 0, 5));
    send_word(make_arm(0, 65535));
    send_word(make_report(0, 1, 16'h0000, 0, 0, 0, 0, 0, 0, 65535));
    send_word(make_arm(0, 10));
    send_word(make_report(0, 1, 16'hA5A5, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_report(0, 0, 16'hA5A5, 100, 100, 100, 100, 200, 200, 0));
    send_word(make_report(0, 1, 16'hA5A5, 0, 0, 0, 0, 0, 0, 100));
    send_word(make_arm(0, 0));
    send_word(make_report(0, 1, 16'hA5A5, 0, 0, 0, 0, 0, 0, 1));
    send_word(make_report(2, 1, 16'h8001, 20000, -20000, 9000, -9000, 200, 100, 3));
    send_word(make_report(3, 1, 16'h7FFE, 12345, -12345, -32768, 32767, 31, 30, 7));
    send_word(make_arm(3, 1));
    send_word(make_report(3, 1, 16'h7FFE, 0, 0, 0, 0, 0, 0, 2));
    settle();
  endtask

  task automatic test_register_extremes();
    program_regs(0, 0, 0, 0, 15);
    send_word(make_report(0, 1, 16'h0000, 0, 1, -1, -32768, 0, 1, 0));
    send_word(make_report(0, 1, 16'hFFFF, 32767, -32767, 16384, -16384, 255, 255, 0));
    settle();
    // full-scale dead zones: everything falls inside
    program_regs(32767, 255, 32767, 5, 5);
    send_word(make_report(1, 1, 16'h0000, 32767, -32768, 1, -1, 255, 255, 0));
    settle();
    program_regs(32766, 254, 32766, 15, 15);
    send_word(make_report(2, 1, 16'h00FF, 32767, -32767, 32766, -32768, 255, 254, 0));
    settle();
  endtask

  task automatic test_press_threshold();
    int lvl;
    lvl = int'($urandom_range(40, 250));
    program_regs(7849, 30, rescale_mag(lvl, 30, TRIG_SPAN), 3, 3);
    send_word(make_report(3, 1, 16'h0000, 0, 0, 0, 0, lvl, lvl + 1, 0));
    send_word(make_report(3, 1, 16'h0008, 0, 0, 0, 0, lvl + 1, lvl, 0));
    send_word(make_report(3, 1, 16'h0000, 0, 0, 0, 0, lvl, lvl, 0));
    settle();
  endtask

  task automatic test_unused_registers();
    for (int i = int'(gpc_pkg::REG_RTRIG_BIT) + 1; i < 2 ** gpc_pkg::CFG_IDX_W; i++)
      write_reg(gpc_pkg::CFG_IDX_W'(i), 16'($urandom()), i == 2 ** gpc_pkg::CFG_IDX_W - 1);
    repeat (3) send_word(random_word());
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned sdz, tdz, thr;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        program_regs(7849, 30, 16384, 10, 11);
      end else begin
        case ($urandom_range(0, 4))
          0: sdz = 0;
          1: sdz = 32767;
          2: sdz = $urandom_range(0, 32767);
          default: sdz = $urandom_range(2000, 12000);
        endcase
        case ($urandom_range(0, 4))
          0: tdz = 0;
          1: tdz = 255;
          2: tdz = $urandom_range(0, 255);
          default: tdz = $urandom_range(10, 60);
        endcase
        case ($urandom_range(0, 3))
          0: thr = 0;
          1: thr = 32767;
          default: thr = $urandom_range(0, 32767);
        endcase
        program_regs(sdz, tdz, thr, $urandom_range(0, 15), $urandom_range(0, 15));
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
        if (p == 1 && n == PHASE_WORDS / 2) wait_results();
      end
      settle();
    end
  endtask

  // a stall burst is always followed by out_ready high before the next one begins
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result word for pad %0d with none expected", $time, out_pad_index);
        errors++;
      end else begin
        want_r = pending_reports.pop_front();
        check_field("pad_index", 16'(want_r.pad), 16'(out_pad_index));
        check_field("connected", 16'(want_r.connected), 16'(out_connected));
        check_field("buttons", want_r.buttons, out_buttons);
        check_field("pressed_edges", want_r.pressed, out_pressed_edges);
        check_field("released_edges", want_r.released, out_released_edges);
        check_field("left_x", want_r.lx, out_left_x);
        check_field("left_y", want_r.ly, out_left_y);
        check_field("right_x", want_r.rx, out_right_x);
        check_field("right_y", want_r.ry, out_right_y);
        check_field("left_trigger", 16'(want_r.lt), 16'(out_left_trigger));
        check_field("right_trigger", 16'(want_r.rt), 16'(out_right_trigger));
        check_field("vibration_stop", 16'(want_r.vib_stop), 16'(out_vibration_stop));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_action <= ACT_REPORT;
    in_pad_index <= '0;
    in_poll_ok <= 1'b0;
    in_raw_buttons <= '0;
    in_raw_left_x <= '0;
    in_raw_left_y <= '0;
    in_raw_right_x <= '0;
    in_raw_right_y <= '0;
    in_raw_left_trigger <= '0;
    in_raw_right_trigger <= '0;
    in_elapsed_ms <= '0;
    in_vibration_ms <= '0;
    out_ready <= 1'b0;
    dz_stick = 7849;
    dz_trig = 30;
    press_thr = 16384;
    ltrig_bit = 10;
    rtrig_bit = 11;
    for (int i = 0; i < gpc_pkg::NUM_PADS; i++) begin
      held_buttons[i] = '0;
      pad_live[i] = 1'b0;
      rumble_ms[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_press_threshold();
    test_unused_registers();
    test_random_traffic();
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/gpc_pkg.sv
src/gpc_front.sv
src/gpc_queue.sv
src/gpc_divider.sv
src/gpc_back.sv
src/gamepad_report_conditioner.sv
src/gpc_checker.sv
bench/tb.sv
